// ===== rtl/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types, constants and stage records shared by the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int ONE           = 1 << FRACTION_BITS;
	localparam int DEG_PER_SEC   = 60;
	localparam int CHAN_MAX      = 255;
	localparam int W_FULL        = DEG_PER_SEC * ONE;
	localparam int DEN_SHIFT     = 2 * FRACTION_BITS;

	// hue / 60 as multiply by reciprocal, exact for all 16-bit hues
	localparam int HUE_SHIFT     = 22;
	localparam int HUE_RECIP     = ((1 << HUE_SHIFT) + DEG_PER_SEC - 1) / DEG_PER_SEC;

	// y / 60 for y below the saturation limit
	localparam int Q_SHIFT       = 20;
	localparam int Q_RECIP       = ((1 << Q_SHIFT) + DEG_PER_SEC - 1) / DEG_PER_SEC;
	localparam int Q_LIMIT       = (CHAN_MAX + 1) * DEG_PER_SEC;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		logic [15:0] hue;
		logic [8:0]  saturation;
		logic [8:0]  brightness_value;
	} pixel_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [31:0] packed_pixel;
	} color_t;

	// after hue decode
	typedef struct packed {
		sector_t     sec;
		logic [5:0]  rem;
		logic [8:0]  sat;
		logic [8:0]  val;
	} decode_t;

	// raw products, before scaling by 255
	typedef struct packed {
		sector_t            sec;
		logic [8:0]         vv;
		logic signed [20:0] pp;
		logic signed [26:0] pq;
		logic signed [26:0] pt;
	} prod_t;

	// scaled and shifted, ready for the final divide by 60
	typedef struct packed {
		sector_t     sec;
		logic [7:0]  vv;
		logic [7:0]  p;
		logic        q_zero;
		logic        q_sat;
		logic [13:0] q_y;
		logic        t_zero;
		logic        t_sat;
		logic [13:0] t_y;
	} scaled_t;

endpackage

// ===== rtl/hsvrgb_sector.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_sector
// Two stages: hue / 60 by reciprocal, then remainder and sector code.
// ----------------------------------------------------------------------------
module hsvrgb_sector import hsvrgb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  pixel_t  pixel,
	output logic    out_valid,
	output decode_t dec
);

	logic        valid_s1;
	logic [10:0] quot_s1;
	pixel_t      pix_s1;
	logic        valid_s2;
	decode_t     dec_s2;

	logic [32:0] quot_prod;
	logic [15:0] quot_x60;
	logic [15:0] rem_full;

	assign quot_prod = {17'd0, pixel.hue} * 33'(HUE_RECIP);
	assign quot_x60  = 16'({5'd0, quot_s1} * 16'(DEG_PER_SEC));
	assign rem_full  = pix_s1.hue - quot_x60;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		quot_s1 <= quot_prod[HUE_SHIFT +: 11];
		pix_s1  <= pixel;
		dec_s2.rem <= rem_full[5:0];
		dec_s2.sat <= pix_s1.saturation;
		dec_s2.val <= pix_s1.brightness_value;
		if (quot_s1 >= 11'(SEC_MAG_RED))
			dec_s2.sec <= SEC_MAG_RED;
		else
			dec_s2.sec <= sector_t'(quot_s1[2:0]);
	end

	assign out_valid = valid_s2;
	assign dec       = dec_s2;

endmodule

// ===== rtl/hsvrgb_weight.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_weight
// Two stages: saturation weights for p, q and t, then products with value.
// ----------------------------------------------------------------------------
module hsvrgb_weight import hsvrgb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  decode_t dec,
	output logic    out_valid,
	output prod_t   prod
);

	logic               valid_s3;
	sector_t            sec_s3;
	logic [8:0]         val_s3;
	logic signed [10:0] wp_s3;
	logic signed [16:0] wq_s3;
	logic signed [16:0] wt_s3;
	logic               valid_s4;
	prod_t              prod_s4;

	logic [5:0]  rem_inv;
	logic [14:0] rs;
	logic [14:0] rts;
	logic [16:0] vv_full;

	assign rem_inv = 6'(DEG_PER_SEC) - dec.rem;
	assign rs      = {9'd0, dec.rem} * {6'd0, dec.sat};
	assign rts     = {9'd0, rem_inv} * {6'd0, dec.sat};
	assign vv_full = {8'd0, val_s3} * 17'(CHAN_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		sec_s3 <= dec.sec;
		val_s3 <= dec.val;
		wp_s3  <= 11'(ONE) - {2'd0, dec.sat};
		wq_s3  <= 17'(W_FULL) - {2'd0, rs};
		wt_s3  <= 17'(W_FULL) - {2'd0, rts};

		prod_s4.sec <= sec_s3;
		prod_s4.vv  <= vv_full[FRACTION_BITS +: 9];
		prod_s4.pp  <= $signed({1'b0, val_s3}) * wp_s3;
		prod_s4.pq  <= $signed({1'b0, val_s3}) * wq_s3;
		prod_s4.pt  <= $signed({1'b0, val_s3}) * wt_s3;
	end

	assign out_valid = valid_s4;
	assign prod      = prod_s4;

endmodule

// ===== rtl/hsvrgb_scale.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_scale
// One stage: scale by 255, drop the fraction bits and flag clamps.
// ----------------------------------------------------------------------------
module hsvrgb_scale import hsvrgb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  prod_t   prod,
	output logic    out_valid,
	output scaled_t scaled
);

	logic    valid_s5;
	scaled_t scaled_s5;

	logic signed [28:0] pp_ext;
	logic signed [28:0] p_num;
	logic signed [34:0] pq_ext;
	logic signed [34:0] pt_ext;
	logic signed [34:0] q_num;
	logic signed [34:0] t_num;
	logic [8:0]         p_y;
	logic [14:0]        q_y;
	logic [14:0]        t_y;

	assign pp_ext = 29'(prod.pp);
	assign pq_ext = 35'(prod.pq);
	assign pt_ext = 35'(prod.pt);
	assign p_num  = (pp_ext <<< 8) - pp_ext;
	assign q_num  = (pq_ext <<< 8) - pq_ext;
	assign t_num  = (pt_ext <<< 8) - pt_ext;
	assign p_y    = p_num[DEN_SHIFT +: 9];
	assign q_y    = q_num[DEN_SHIFT +: 15];
	assign t_y    = t_num[DEN_SHIFT +: 15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s5 <= 1'b0;
		else
			valid_s5 <= in_valid;
	end

	always_ff @(posedge clk) begin
		scaled_s5.sec <= prod.sec;
		scaled_s5.vv  <= (prod.vv > 9'(CHAN_MAX)) ? 8'(CHAN_MAX) : prod.vv[7:0];
		if (prod.pp < 0)
			scaled_s5.p <= 8'd0;
		else if (p_y > 9'(CHAN_MAX))
			scaled_s5.p <= 8'(CHAN_MAX);
		else
			scaled_s5.p <= p_y[7:0];
		scaled_s5.q_zero <= prod.pq < 0;
		scaled_s5.q_sat  <= q_y >= 15'(Q_LIMIT);
		scaled_s5.q_y    <= q_y[13:0];
		scaled_s5.t_zero <= prod.pt < 0;
		scaled_s5.t_sat  <= t_y >= 15'(Q_LIMIT);
		scaled_s5.t_y    <= t_y[13:0];
	end

	assign out_valid = valid_s5;
	assign scaled    = scaled_s5;

endmodule

// ===== rtl/hsvrgb_out.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_out
// Final stage: divide q and t by 60, pick channels by sector, pack GRBW.
// ----------------------------------------------------------------------------
module hsvrgb_out import hsvrgb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  scaled_t scaled,
	output logic    out_valid,
	output color_t  color
);

	logic   valid_s6;
	color_t color_s6;

	logic [28:0] q_prod;
	logic [28:0] t_prod;
	logic [7:0]  q;
	logic [7:0]  t;
	logic [7:0]  rd;
	logic [7:0]  gr;
	logic [7:0]  bl;

	assign q_prod = {15'd0, scaled.q_y} * 29'(Q_RECIP);
	assign t_prod = {15'd0, scaled.t_y} * 29'(Q_RECIP);

	always_comb begin
		if (scaled.q_zero)
			q = 8'd0;
		else if (scaled.q_sat)
			q = 8'(CHAN_MAX);
		else
			q = q_prod[Q_SHIFT +: 8];
		if (scaled.t_zero)
			t = 8'd0;
		else if (scaled.t_sat)
			t = 8'(CHAN_MAX);
		else
			t = t_prod[Q_SHIFT +: 8];
	end

	always_comb begin
		case (scaled.sec)
			SEC_RED_YEL: begin
				rd = scaled.vv; gr = t;         bl = scaled.p;
			end
			SEC_YEL_GRN: begin
				rd = q;         gr = scaled.vv; bl = scaled.p;
			end
			SEC_GRN_CYN: begin
				rd = scaled.p;  gr = scaled.vv; bl = t;
			end
			SEC_CYN_BLU: begin
				rd = scaled.p;  gr = q;         bl = scaled.vv;
			end
			SEC_BLU_MAG: begin
				rd = t;         gr = scaled.p;  bl = scaled.vv;
			end
			default: begin
				rd = scaled.vv; gr = scaled.p;  bl = q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s6 <= 1'b0;
		else
			valid_s6 <= in_valid;
	end

	always_ff @(posedge clk) begin
		color_s6.red          <= rd;
		color_s6.green        <= gr;
		color_s6.blue         <= bl;
		color_s6.packed_pixel <= {gr, rd, bl, 8'd0};
	end

	assign out_valid = valid_s6;
	assign color     = color_s6;

endmodule

// ===== rtl/hsv_to_rgb_pixel.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel
// HSV to RGB pixel converter, six-stage pipeline.
//
// input: a transaction is taken at a rising edge with start high and busy
// low; pixel carries hue in degrees, saturation and value in 1/256 units.
// busy is held low, so one pixel can be taken on every clock.
// output: done is high for one cycle with color holding red, green, blue
// and the packed GRBW word (white zero); the receiver takes it at the
// edge that ends that cycle and cannot hold it off.
// pipeline: done rises once the pixel has passed all six register
// stages in order: hue decode, remainder, weights, products, scaling,
// divide/select; throughput one pixel per cycle, as busy never stalls.
// reset: arst_n clears all stage valid bits; no transaction is in flight
// after reset and done stays low until a new pixel has gone through.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel import hsvrgb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  pixel_t pixel,
	output logic   done,
	output color_t color
);

	logic    dec_valid;
	decode_t dec;
	logic    prod_valid;
	prod_t   prod;
	logic    scaled_valid;
	scaled_t scaled;

	assign busy = 1'b0;

	hsvrgb_sector u_sector (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.pixel     (pixel),
		.out_valid (dec_valid),
		.dec       (dec)
	);

	hsvrgb_weight u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.dec       (dec),
		.out_valid (prod_valid),
		.prod      (prod)
	);

	hsvrgb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.prod      (prod),
		.out_valid (scaled_valid),
		.scaled    (scaled)
	);

	hsvrgb_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scaled_valid),
		.scaled    (scaled),
		.out_valid (done),
		.color     (color)
	);

endmodule
